// ===== design/rgbpwm_pkg.sv =====
`default_nettype none

package rgbpwm_pkg;

    localparam int PIXELS      = 64;
    localparam int RESET_SLOTS = 64;

    localparam int LED_W = $clog2(PIXELS);
    localparam int GAP_W = $clog2(RESET_SLOTS);
    localparam int ROW_W = 24;

    // request modes
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_REFRESH = 2'd2;

    // PWM compare codes
    localparam logic [1:0] SYM_IDLE = 2'd0;
    localparam logic [1:0] SYM_ZERO = 2'd1;
    localparam logic [1:0] SYM_ONE  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [1:0] symbol;
        logic       symbol_valid;
        logic       active;
    } out_item_t;

    // pixel store port: one row (G,R,B) per LED
    typedef struct packed {
        logic             wr_en;
        logic [LED_W-1:0] wr_addr;
        logic [ROW_W-1:0] wr_data;
        logic             rd_en;
        logic [LED_W-1:0] rd_addr;
    } pmem_ctl_t;

endpackage

`default_nettype wire

// ===== design/rgb_led_pwm_frame_encoder.sv =====
// Latency: a result is presented on m_ the cycle after its request is accepted.
// Throughput: one request per cycle; the pixel store's registered read feeds
// the single output stage, and s_ready stays high while m_ready is high.
// Reset (aresetn low, synchronous): frame position to zero, running and refresh
// pending set so a frame goes out, all pixel rows read as zero until written.
`default_nettype none

module rgb_led_pwm_frame_encoder
    import rgbpwm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_payload
);

    // frame position
    logic [LED_W-1:0] led_reg, led_next;
    logic [1:0]       byte_reg, byte_next;
    logic [2:0]       bit_reg, bit_next;
    logic             in_gap_reg, in_gap_next;
    logic [GAP_W-1:0] gap_reg, gap_next;
    logic             running_reg, running_next;
    logic             pending_reg, pending_next;

    // output stage
    logic             out_valid_reg, out_valid_next;
    logic             sym_valid_reg, sym_valid_next;
    logic             data_slot_reg, data_slot_next;
    logic             active_reg, active_next;
    logic [1:0]       byte_q_reg, byte_q_next;
    logic [2:0]       bit_q_reg, bit_q_next;

    logic             accept;
    logic             tick;
    logic             at_start;
    pmem_ctl_t        pmem_ctl;
    logic [ROW_W-1:0] row_data;
    logic [7:0]       cur_byte;
    logic             cur_bit;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign tick    = accept && (s_payload.mode == MODE_TICK) && running_reg;
    assign at_start = !in_gap_reg && (led_reg == '0) && (byte_reg == 2'd0)
                      && (bit_reg == 3'd0);

    always_comb begin
        pmem_ctl.wr_en   = accept && (s_payload.mode == MODE_WRITE)
                           && (s_payload.pixel_index < 8'(PIXELS));
        pmem_ctl.wr_addr = s_payload.pixel_index[LED_W-1:0];
        pmem_ctl.wr_data = {s_payload.green, s_payload.red, s_payload.blue};
        pmem_ctl.rd_en   = tick && !in_gap_reg;
        pmem_ctl.rd_addr = led_reg;
    end

    rgbpwm_pixel_mem u_pixel_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (pmem_ctl),
        .rd_data (row_data)
    );

    always_comb begin
        led_next     = led_reg;
        byte_next    = byte_reg;
        bit_next     = bit_reg;
        in_gap_next  = in_gap_reg;
        gap_next     = gap_reg;
        running_next = running_reg;
        pending_next = pending_reg;

        out_valid_next = out_valid_reg && !m_ready;
        sym_valid_next = sym_valid_reg;
        data_slot_next = data_slot_reg;
        active_next    = active_reg;
        byte_q_next    = byte_q_reg;
        bit_q_next     = bit_q_reg;

        if (accept) begin
            out_valid_next = 1'b1;
            sym_valid_next = 1'b0;
            data_slot_next = 1'b0;
            byte_q_next    = byte_reg;
            bit_q_next     = bit_reg;

            case (s_payload.mode)
                MODE_TICK: begin
                    if (running_reg) begin
                        sym_valid_next = 1'b1;
                        data_slot_next = !in_gap_reg;
                        if (at_start) begin
                            pending_next = 1'b0;
                        end
                        if (!in_gap_reg) begin
                            bit_next = bit_reg + 3'd1;
                            if (bit_reg == 3'd7) begin
                                byte_next = byte_reg + 2'd1;
                                if (byte_reg == 2'd2) begin
                                    byte_next = 2'd0;
                                    led_next  = led_reg + LED_W'(1);
                                    if (led_reg == LED_W'(PIXELS - 1)) begin
                                        led_next    = '0;
                                        in_gap_next = 1'b1;
                                        gap_next    = '0;
                                    end
                                end
                            end
                        end else begin
                            gap_next = gap_reg + GAP_W'(1);
                            if (gap_reg == GAP_W'(RESET_SLOTS - 1)) begin
                                gap_next     = '0;
                                in_gap_next  = 1'b0;
                                running_next = pending_next;
                            end
                        end
                    end
                end
                MODE_REFRESH: begin
                    pending_next = 1'b1;
                    running_next = 1'b1;
                end
                default: begin
                end
            endcase

            active_next = running_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_reg       <= '0;
            byte_reg      <= 2'd0;
            bit_reg       <= 3'd0;
            in_gap_reg    <= 1'b0;
            gap_reg       <= '0;
            running_reg   <= 1'b1;
            pending_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            sym_valid_reg <= 1'b0;
            data_slot_reg <= 1'b0;
            active_reg    <= 1'b0;
        end else begin
            led_reg       <= led_next;
            byte_reg      <= byte_next;
            bit_reg       <= bit_next;
            in_gap_reg    <= in_gap_next;
            gap_reg       <= gap_next;
            running_reg   <= running_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            sym_valid_reg <= sym_valid_next;
            data_slot_reg <= data_slot_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_q_reg <= byte_q_next;
        bit_q_reg  <= bit_q_next;
    end

    // row is G,R,B from the top down
    always_comb begin
        case (byte_q_reg)
            2'd0:    cur_byte = row_data[23:16];
            2'd1:    cur_byte = row_data[15:8];
            default: cur_byte = row_data[7:0];
        endcase
        cur_bit = cur_byte[3'd7 - bit_q_reg];
    end

    assign m_valid                = out_valid_reg;
    assign m_payload.symbol       = data_slot_reg ? (cur_bit ? SYM_ONE : SYM_ZERO)
                                                  : SYM_IDLE;
    assign m_payload.symbol_valid = sym_valid_reg;
    assign m_payload.active       = active_reg;

`ifndef ASSERT_OFF
    a_gap_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_gap_reg |-> (led_reg == '0) && (byte_reg == 2'd0) && (bit_reg == 3'd0))
        else $error("data position not cleared during reset gap");

    a_stopped_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> at_start && (gap_reg == '0))
        else $error("stopped away from frame start");

    a_byte_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_reg != 2'd3)
        else $error("byte select out of range");

    a_gap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(gap_reg) < RESET_SLOTS)
        else $error("gap counter out of range");

    a_idle_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.symbol_valid |-> m_payload.symbol == SYM_IDLE)
        else $error("symbol without a slot");
`endif

endmodule

`default_nettype wire

// ===== design/rgbpwm_pixel_mem.sv =====
`default_nettype none

module rgbpwm_pixel_mem
    import rgbpwm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire pmem_ctl_t        ctl,
    output logic      [ROW_W-1:0] rd_data
);

    logic [ROW_W-1:0] mem [PIXELS];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_hit_reg;
    logic [PIXELS-1:0] row_valid_reg;
    logic [PIXELS-1:0] row_valid_next;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    always_comb begin
        row_valid_next = row_valid_reg;
        if (ctl.wr_en) begin
            row_valid_next[ctl.wr_addr] = 1'b1;
        end
    end

    // rows never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            if (ctl.rd_en) begin
                rd_hit_reg <= row_valid_reg[ctl.rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== test/rgb_led_pwm_frame_encoder_test.sv =====
module rgb_led_pwm_frame_encoder_test
    import rgbpwm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DATA_SLOTS      = PIXELS * 24;
    localparam int unsigned FRAME_SLOTS     = DATA_SLOTS + RESET_SLOTS;
    localparam logic [1:0]  MODE_UNUSED     = 2'd3;
    localparam int unsigned RANDOM_REQUESTS = 1080;
    localparam int unsigned CYCLE_LIMIT     = 900_000;

    // Tracks the LED frame the block should be sending and the symbols owed.
    class frame_scoreboard;
        logic [7:0]  pixel_store [3*PIXELS];
        int unsigned slot_pos;
        bit          running;
        bit          refresh_pending;
        int unsigned frames_begun;
        int unsigned error_count;
        out_item_t   expected_symbols [$];

        function new();
            foreach (pixel_store[i]) pixel_store[i] = 8'h00;
            slot_pos        = 0;
            running         = 1'b1;
            refresh_pending = 1'b1;
            frames_begun    = 0;
            error_count     = 0;
        endfunction

        function void note_request(in_item_t req);
            out_item_t   want;
            logic [7:0]  px;
            int unsigned base;
            want = '0;
            want.symbol = SYM_IDLE;
            case (req.mode)
                MODE_TICK: begin
                    if (running) begin
                        if (slot_pos == 0) begin
                            refresh_pending = 1'b0;
                            frames_begun++;
                        end
                        // data bits MSB first; byte is read when its bit goes out
                        if (slot_pos < DATA_SLOTS) begin
                            px = pixel_store[slot_pos >> 3];
                            want.symbol = px[7 - (slot_pos % 8)] ? SYM_ONE : SYM_ZERO;
                        end
                        want.symbol_valid = 1'b1;
                        slot_pos++;
                        if (slot_pos >= FRAME_SLOTS) begin
                            slot_pos = 0;
                            running  = refresh_pending;
                        end
                    end
                end
                MODE_WRITE: begin
                    if (req.pixel_index < PIXELS) begin
                        base = req.pixel_index * 3;
                        pixel_store[base]     = req.green;
                        pixel_store[base + 1] = req.red;
                        pixel_store[base + 2] = req.blue;
                    end
                end
                MODE_REFRESH: begin
                    refresh_pending = 1'b1;
                    running         = 1'b1;
                end
                default: ;
            endcase
            want.active = running;
            expected_symbols.push_back(want);
        endfunction

        function void check_symbol(out_item_t got);
            out_item_t want;
            if (expected_symbols.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: sym=%0d valid=%0b active=%0b",
                             got.symbol, got.symbol_valid, got.active);
                return;
            end
            want = expected_symbols.pop_front();
            if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
                got.active !== want.active) begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch: sym/valid/active expected %0d/%0b/%0b got %0d/%0b/%0b",
                             want.symbol, want.symbol_valid, want.active,
                             got.symbol, got.symbol_valid, got.active);
            end
        endfunction
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;

    frame_scoreboard sb = new();
    bit              idle_off = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     cycle_count = 0;

    rgb_led_pwm_frame_encoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL rgb_led_pwm_frame_encoder");
            $finish;
        end
    end

    // result side: check, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_symbol(m_payload);
        if (stall_left == 0 && !idle_off && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic in_item_t make_item(logic [1:0] mode, logic [7:0] idx,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_item_t req;
        req.mode        = mode;
        req.pixel_index = idx;
        req.red         = r;
        req.green       = g;
        req.blue        = b;
        return req;
    endfunction

    // Mostly ticks so frames run to their end; while a frame runs, refreshes come
    // only in even frames, so some frames restart and others stop.
    function automatic in_item_t make_request();
        in_item_t    req;
        int unsigned pick;
        req = make_item(MODE_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 999);
        if (!sb.running) begin
            if (pick < 100)
                req.mode = MODE_REFRESH;
            else if (pick < 400)
                req.mode = MODE_WRITE;
            else if (pick < 410)
                req.mode = MODE_UNUSED;
        end else begin
            if (sb.frames_begun % 2 == 0 && pick < 2)
                req.mode = MODE_REFRESH;
            else if (pick < 120)
                req.mode = MODE_WRITE;
            else if (pick < 130)
                req.mode = MODE_UNUSED;
        end
        if (req.mode == MODE_WRITE && $urandom_range(0, 9) != 0)
            req.pixel_index = 8'($urandom_range(0, PIXELS - 1));
        return req;
    endfunction

    function automatic bit takes_effect(in_item_t req);
        return (req.mode == MODE_TICK && sb.running) || req.mode == MODE_REFRESH ||
               (req.mode == MODE_WRITE && req.pixel_index < PIXELS);
    endfunction

    task automatic send_request(input in_item_t req);
        s_payload <= req;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
    endtask

    task automatic hold_sender(input int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_symbols.size() != 0) @(posedge aclk);
    endtask

    initial begin
        in_item_t    req;
        bit          counts;
        int unsigned sent;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_request(make_item(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        // write then tick at once: the new green byte must already be used
        send_request(make_item(MODE_WRITE, 8'd0, 8'h00, 8'hA5, 8'hFF));
        send_request(make_item(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_item(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_item(MODE_WRITE, 8'd0, 8'hFF, 8'h5A, 8'h00));
        send_request(make_item(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_item(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_item(MODE_WRITE, 8'(PIXELS - 1), 8'hFF, 8'hFF, 8'h00));
        send_request(make_item(MODE_WRITE, 8'(PIXELS), 8'hFF, 8'hFF, 8'hFF));
        send_request(make_item(MODE_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_item(MODE_WRITE, 8'd1, 8'h00, 8'hFF, 8'h80));
        // refresh mid-frame: frame keeps going, another follows
        send_request(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
        repeat (4) send_request(make_item(MODE_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_item(MODE_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00));
        send_request(make_item(MODE_WRITE, 8'd0, 8'h00, 8'h00, 8'h00));

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            idle_off = (sent >= RANDOM_REQUESTS - 400) || ((sent / 300) % 4 == 3);
            if (!idle_off && $urandom_range(0, 5) == 0)
                hold_sender($urandom_range(1, 19));
            req = make_request();
            counts = takes_effect(req);
            send_request(req);
            if (counts) begin
                sent++;
                if (sent % 900 == 0)
                    drain_results();
            end
        end

        s_valid <= 1'b0;
        while (sb.expected_symbols.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.error_count == 0 && sb.expected_symbols.size() == 0) begin
            $display("PASS rgb_led_pwm_frame_encoder");
        end else begin
            $display("FAIL rgb_led_pwm_frame_encoder");
        end
        $finish;
    end

endmodule
